FILE: sv/lps_pkg.sv
// shared types and constants for the line pixel stepper
package lps_pkg;

    // field widths fixed by the interface
    localparam int COORD_BITS    = 12;
    localparam int DELTA_BITS    = COORD_BITS + 1;
    localparam int ERR_BITS      = COORD_BITS + 2;
    localparam int CFG_BITS      = 11;
    localparam int CFG_IDX_BITS  = 2;
    localparam int COLOR_BITS    = 8;
    localparam int ADDR_BITS     = 20;
    localparam int ADDR_FULL_BITS = 2 * CFG_BITS;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_CANVAS_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CANVAS_HEIGHT = 2'd1;

    // command codes
    typedef enum logic {
        CMD_START = 1'b0,
        CMD_NEXT  = 1'b1
    } t_cmd;

    // one input request
    typedef struct packed {
        t_cmd                          command;
        logic signed [COORD_BITS-1:0]  x_start;
        logic signed [COORD_BITS-1:0]  y_start;
        logic signed [COORD_BITS-1:0]  x_end;
        logic signed [COORD_BITS-1:0]  y_end;
        logic [COLOR_BITS-1:0]         line_color;
    } t_in_item;

    // one result request
    typedef struct packed {
        logic                          valid_res;
        logic signed [COORD_BITS-1:0]  pixel_x;
        logic signed [COORD_BITS-1:0]  pixel_y;
        logic                          on_canvas;
        logic [ADDR_BITS-1:0]          pixel_address;
        logic [COLOR_BITS-1:0]         pixel_color;
        logic                          last;
    } t_out_item;

endpackage

FILE: sv/line_pixel_stepper_core.sv
// line pixel stepper top level: bresenham stepping with canvas clip and address
//
// Each request either starts a line (endpoints and grey level are latched, the
// start pixel comes out) or asks for the next pixel of the line in progress;
// every request gives exactly one result, with valid_res low when a next
// request finds no line active. The end point is not drawn unless it equals
// the start point. One request is taken per clock and passes two registers:
// an input register where the line deltas, step directions and initial error
// are formed, then one pass that emits the pixel, forms y*width+x with a
// single 11x11 multiplier and takes one bresenham step into the line state
// and the result register. The input stalls only while both registers are
// full and the result is stalled. Canvas width and height are clamped to
// MAX_WIDTH and MAX_HEIGHT when written; write them only while no request
// is in flight.
module line_pixel_stepper_core #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // request channel
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  lps_pkg::t_in_item                    i_in_item,
    // result channel
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output lps_pkg::t_out_item                   o_out_item,
    // configuration writes
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [lps_pkg::CFG_IDX_BITS-1:0]     i_cfg_index,
    input  logic [lps_pkg::CFG_BITS-1:0]         i_cfg_data
);
    import lps_pkg::*;

    localparam int LIM_BITS = CFG_BITS + 2;
    localparam logic [LIM_BITS-1:0] MAX_W = LIM_BITS'(MAX_WIDTH);
    localparam logic [LIM_BITS-1:0] MAX_H = LIM_BITS'(MAX_HEIGHT);
    localparam logic [CFG_BITS-1:0] WIDTH_RESET =
        (MAX_WIDTH < 1024) ? CFG_BITS'(MAX_WIDTH) : CFG_BITS'(1024);
    localparam logic [CFG_BITS-1:0] HEIGHT_RESET =
        (MAX_HEIGHT < 1024) ? CFG_BITS'(MAX_HEIGHT) : CFG_BITS'(1024);

    // clamped canvas size
    logic [CFG_BITS-1:0] r_width;
    logic [CFG_BITS-1:0] r_height;

    // input stage
    logic                          r_s1_valid;
    t_cmd                          r_s1_cmd;
    logic signed [COORD_BITS-1:0]  r_s1_x0;
    logic signed [COORD_BITS-1:0]  r_s1_y0;
    logic signed [COORD_BITS-1:0]  r_s1_x1;
    logic signed [COORD_BITS-1:0]  r_s1_y1;
    logic [COLOR_BITS-1:0]         r_s1_color;
    logic [DELTA_BITS-1:0]         r_s1_dx;
    logic [DELTA_BITS-1:0]         r_s1_dy;
    logic                          r_s1_sxn;
    logic                          r_s1_syn;
    logic signed [ERR_BITS-1:0]    r_s1_err;

    // line state
    logic                          r_active;
    logic signed [COORD_BITS-1:0]  r_cx;
    logic signed [COORD_BITS-1:0]  r_cy;
    logic signed [COORD_BITS-1:0]  r_tx;
    logic signed [COORD_BITS-1:0]  r_ty;
    logic [DELTA_BITS-1:0]         r_dx;
    logic [DELTA_BITS-1:0]         r_dy;
    logic                          r_sxn;
    logic                          r_syn;
    logic signed [ERR_BITS-1:0]    r_err;
    logic [COLOR_BITS-1:0]         r_color;

    // result register
    logic                          r_out_valid;
    t_out_item                     r_out_item;

    logic in_accept;
    logic s1_move;

    // handshake
    assign s1_move    = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !s1_move;
    assign in_accept  = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // configuration registers, clamped on write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_CANVAS_WIDTH: begin
                    r_width <= ({2'b00, i_cfg_data} > MAX_W) ?
                               CFG_BITS'(MAX_WIDTH) : i_cfg_data;
                end
                CFG_CANVAS_HEIGHT: begin
                    r_height <= ({2'b00, i_cfg_data} > MAX_H) ?
                                CFG_BITS'(MAX_HEIGHT) : i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // line setup terms from the incoming endpoints
    logic [DELTA_BITS-1:0] diff_x;
    logic [DELTA_BITS-1:0] diff_y;
    logic [DELTA_BITS-1:0] abs_x;
    logic [DELTA_BITS-1:0] abs_y;
    logic signed [ERR_BITS-1:0] err_init;

    always_comb begin
        diff_x = {i_in_item.x_end[COORD_BITS-1], i_in_item.x_end}
               - {i_in_item.x_start[COORD_BITS-1], i_in_item.x_start};
        diff_y = {i_in_item.y_end[COORD_BITS-1], i_in_item.y_end}
               - {i_in_item.y_start[COORD_BITS-1], i_in_item.y_start};
        abs_x  = diff_x[DELTA_BITS-1] ? (~diff_x + 1'b1) : diff_x;
        abs_y  = diff_y[DELTA_BITS-1] ? (~diff_y + 1'b1) : diff_y;
        if (abs_x > abs_y) begin
            err_init = $signed({1'b0, abs_x >> 1});
        end else begin
            err_init = -$signed({1'b0, abs_y >> 1});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_cmd   <= i_in_item.command;
            r_s1_x0    <= i_in_item.x_start;
            r_s1_y0    <= i_in_item.y_start;
            r_s1_x1    <= i_in_item.x_end;
            r_s1_y1    <= i_in_item.y_end;
            r_s1_color <= i_in_item.line_color;
            r_s1_dx    <= abs_x;
            r_s1_dy    <= abs_y;
            r_s1_sxn   <= diff_x[DELTA_BITS-1] || (diff_x == '0);
            r_s1_syn   <= diff_y[DELTA_BITS-1] || (diff_y == '0);
            r_s1_err   <= err_init;
        end
    end

    // pick fresh line terms on a start, else the stored state
    logic                          use_start;
    logic                          emit;
    logic signed [COORD_BITS-1:0]  w_cx;
    logic signed [COORD_BITS-1:0]  w_cy;
    logic signed [COORD_BITS-1:0]  w_tx;
    logic signed [COORD_BITS-1:0]  w_ty;
    logic [DELTA_BITS-1:0]         w_dx;
    logic [DELTA_BITS-1:0]         w_dy;
    logic                          w_sxn;
    logic                          w_syn;
    logic signed [ERR_BITS-1:0]    w_err;
    logic [COLOR_BITS-1:0]         w_color;

    assign use_start = (r_s1_cmd == CMD_START);
    assign emit      = use_start || r_active;

    always_comb begin
        if (use_start) begin
            w_cx    = r_s1_x0;
            w_cy    = r_s1_y0;
            w_tx    = r_s1_x1;
            w_ty    = r_s1_y1;
            w_dx    = r_s1_dx;
            w_dy    = r_s1_dy;
            w_sxn   = r_s1_sxn;
            w_syn   = r_s1_syn;
            w_err   = r_s1_err;
            w_color = r_s1_color;
        end else begin
            w_cx    = r_cx;
            w_cy    = r_cy;
            w_tx    = r_tx;
            w_ty    = r_ty;
            w_dx    = r_dx;
            w_dy    = r_dy;
            w_sxn   = r_sxn;
            w_syn   = r_syn;
            w_err   = r_err;
            w_color = r_color;
        end
    end

    // one bresenham step
    logic signed [ERR_BITS:0]      err_ext;
    logic signed [ERR_BITS:0]      neg_dx;
    logic signed [ERR_BITS:0]      pos_dx;
    logic signed [ERR_BITS:0]      pos_dy;
    logic signed [ERR_BITS:0]      err_sum;
    logic                          step_x;
    logic                          step_y;
    logic signed [COORD_BITS-1:0]  n_cx;
    logic signed [COORD_BITS-1:0]  n_cy;
    logic signed [ERR_BITS-1:0]    n_err;
    logic                          hit;

    always_comb begin
        err_ext = {w_err[ERR_BITS-1], w_err};
        pos_dx  = $signed({2'b00, w_dx});
        pos_dy  = $signed({2'b00, w_dy});
        neg_dx  = -pos_dx;
        step_x  = err_ext > neg_dx;
        step_y  = err_ext < pos_dy;
        err_sum = err_ext - (step_x ? pos_dy : '0) + (step_y ? pos_dx : '0);
        n_err   = err_sum[ERR_BITS-1:0];
        n_cx    = w_cx + (step_x ? (w_sxn ? {COORD_BITS{1'b1}} : COORD_BITS'(1))
                                 : '0);
        n_cy    = w_cy + (step_y ? (w_syn ? {COORD_BITS{1'b1}} : COORD_BITS'(1))
                                 : '0);
        hit     = (n_cx == w_tx) && (n_cy == w_ty);
    end

    // canvas clip and row-major address of the emitted pixel
    logic                      in_canvas;
    logic [ADDR_FULL_BITS-1:0] addr_full;

    always_comb begin
        in_canvas = !w_cx[COORD_BITS-1] && !w_cy[COORD_BITS-1]
                 && (w_cx < COORD_BITS'(r_width))
                 && (w_cy < COORD_BITS'(r_height));
        addr_full = ADDR_FULL_BITS'(w_cy[COORD_BITS-2:0])
                  * ADDR_FULL_BITS'(r_width)
                  + ADDR_FULL_BITS'(w_cx[COORD_BITS-2:0]);
    end

    // result for this request
    t_out_item n_out_item;

    always_comb begin
        n_out_item = '0;
        if (emit) begin
            n_out_item.valid_res     = 1'b1;
            n_out_item.pixel_x       = w_cx;
            n_out_item.pixel_y       = w_cy;
            n_out_item.on_canvas     = in_canvas;
            n_out_item.pixel_address = in_canvas ? addr_full[ADDR_BITS-1:0] : '0;
            n_out_item.pixel_color   = w_color;
            n_out_item.last          = hit;
        end
    end

    // line state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_cx     <= '0;
            r_cy     <= '0;
            r_tx     <= '0;
            r_ty     <= '0;
            r_dx     <= '0;
            r_dy     <= '0;
            r_sxn    <= 1'b0;
            r_syn    <= 1'b0;
            r_err    <= '0;
            r_color  <= '0;
        end else if (s1_move && emit) begin
            r_active <= !hit;
            r_cx     <= n_cx;
            r_cy     <= n_cy;
            r_tx     <= w_tx;
            r_ty     <= w_ty;
            r_dx     <= w_dx;
            r_dy     <= w_dy;
            r_sxn    <= w_sxn;
            r_syn    <= w_syn;
            r_err    <= n_err;
            r_color  <= w_color;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_move) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out_item <= n_out_item;
        end
    end

endmodule

FILE: sv/lps_checker.sv
// port-level assertions for the line pixel stepper, bound to the top level
module lps_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              o_in_stall,
    input  logic                              o_out_valid,
    input  logic                              i_out_stall,
    input  lps_pkg::t_out_item                o_out_item
);
    import lps_pkg::*;

    // reset empties the result register
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // a stalled result request holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed");

    // a no-line result carries only zeros
    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.valid_res |->
            o_out_item.pixel_x == '0 && o_out_item.pixel_y == '0 &&
            !o_out_item.on_canvas && o_out_item.pixel_address == '0 &&
            o_out_item.pixel_color == '0 && !o_out_item.last)
        else $error("no-line result not zero");

    // clipped pixels get address zero
    a_clip_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.on_canvas |-> o_out_item.pixel_address == '0)
        else $error("clipped pixel has an address");

    // input stalls only behind a waiting stalled result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled with no stalled result");

endmodule

bind line_pixel_stepper_core lps_checker u_lps_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);
